/* sv/lpcq_pkg.sv */
// Package for the line prefix and cursor query filter.
// Holds the query pattern, character codes, widths and the command type.
// No dependencies.
`timescale 1ns / 1ps

package lpcq_pkg;

  localparam int unsigned QueryLen  = 4;
  localparam int unsigned CntW      = $clog2(QueryLen);
  localparam int unsigned PatDepth  = 8;
  localparam int unsigned PatIdxW   = $clog2(PatDepth);
  localparam int unsigned VmW       = 16;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned DecSteps  = VmW;
  localparam int unsigned DecCntW   = $clog2(DecSteps + 1);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned HeadLen   = 6;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharClose = 8'h5D;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [7:0] QueryPat [PatDepth] = '{
    8'h1B, 8'h5B, 8'h36, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] PfxHead [HeadLen] = '{
    8'h5B, 8'h76, 8'h6D, 8'h69, 8'h64, 8'h20
  };

  // One decoded input byte, handed from the front to the back.
  typedef struct packed {
    logic            reply;  // complete query seen
    logic [CntW-1:0] nheld;  // pattern bytes to replay before ch
    logic [7:0]      ch;     // the byte that ended the match attempt
  } cmd_t;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  function automatic logic [7:0] query_byte(input logic [CntW-1:0] idx);
    return QueryPat[PatIdxW'(idx)];
  endfunction

endpackage

/* sv/lpcq_in_if.sv */
// Input channel of the filter: valid/ready handshake and one console byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface lpcq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* sv/lpcq_out_if.sv */
// Output channel of the filter: valid/ready handshake and one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface lpcq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       reply_request;
  logic       last;

  modport source (output valid, output out_byte, output reply_request, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input reply_request, input last,
                  output ready);
endinterface

/* sv/line_prefix_and_cursor_query_filter_top.sv */
// Top level of the console filter: line prefix insertion and cursor query capture.
// Depends on lpcq_pkg, lpcq_in_if, lpcq_out_if, lpcq_dec, lpcq_front, lpcq_fifo, lpcq_back.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          payload
//  in_i      in         valid / ready      data_byte[7:0]
//  out_o     out        valid / ready      out_byte[7:0], reply_request, last
//  cfg       in         cfg_we_i (no wait) cfg_wdata_i[15:0] = vm_number
//
//  A byte that produces a single result transfers every cycle while out_o.ready
//  is high; one output byte leaves per cycle, so a byte that needs the prefix
//  (9..13 bytes) or replays held bytes (0..3) holds the back end until all have left.
//  The front keeps accepting into a two-entry queue while the back is busy.
//  A configuration write starts a decimal conversion; in_i.ready is
//  low meanwhile. Reset clears all control state; no clearing pass is needed.
//  Output results sit in a register that holds while out_o.ready is low.

module line_prefix_and_cursor_query_filter_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lpcq_pkg::VmW-1:0] cfg_wdata_i,
  lpcq_in_if.sink                  in_i,
  lpcq_out_if.source               out_o
);

  lpcq_pkg::digits_t digits;
  lpcq_pkg::cmd_t    push_cmd, head_cmd;
  logic              busy, q_full, push, head_valid, pop;

  // Convert the machine number to decimal digits once per configuration write.
  lpcq_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy),
    .digits_o    (digits)
  );

  // Classify each byte: hold a partial query, or issue a reply or replay command.
  lpcq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .busy_i   (busy),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Decouple classification from emission.
  lpcq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  // Emit prefix, replayed bytes and the current byte, one result per transfer.
  lpcq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .digits_i    (digits),
    .out_o       (out_o)
  );

  // A reply request is always the sole, final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.reply_request |-> out_o.last && (out_o.out_byte == 8'd0))
    else $error("reply request result malformed");

  // Hold off input while the decimal digits are being rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("input taken during digit conversion");

  // The front must never issue a command the queue cannot take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into full queue");

  // A popped command must have been present at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid && !$past(!rst_ni))
    else $error("pop with empty queue");

endmodule

/* sv/lpcq_dec.sv */
// Binary to decimal converter for the machine number (shift-add-3, one bit a cycle).
// Depends on lpcq_pkg.
`timescale 1ns / 1ps

module lpcq_dec (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lpcq_pkg::VmW-1:0]  cfg_wdata_i,
  output logic                      busy_o,
  output lpcq_pkg::digits_t         digits_o
);

  logic [lpcq_pkg::VmW-1:0]     bin_q, bin_d;
  lpcq_pkg::digits_t            bcd_q, bcd_d, adj;
  logic [lpcq_pkg::BcdW-1:0]    adj_bits;
  logic [lpcq_pkg::DecCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    for (int i = 0; i < lpcq_pkg::NumDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign adj_bits = adj;

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      bin_d = cfg_wdata_i;
      bcd_d = '0;
      cnt_d = lpcq_pkg::DecCntW'(lpcq_pkg::DecSteps);
    end else if (cnt_q != '0) begin
      bcd_d = {adj_bits[lpcq_pkg::BcdW-2:0], bin_q[lpcq_pkg::VmW-1]};
      bin_d = {bin_q[lpcq_pkg::VmW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      bcd_q <= '0;
      cnt_q <= '0;
    end else begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o   = (cnt_q != '0);
  assign digits_o = bcd_q;

endmodule

/* sv/lpcq_front.sv */
// Front end: accepts console bytes, tracks the partial query match, issues commands.
// Depends on lpcq_pkg and lpcq_in_if.
`timescale 1ns / 1ps

module lpcq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lpcq_in_if.sink              in_i,
  input  logic                 busy_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lpcq_pkg::cmd_t       cmd_o
);

  logic [lpcq_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      accept, match, complete;

  assign in_i.ready = !q_full_i && !busy_i;
  assign accept     = in_i.valid && in_i.ready;

  // Held bytes always equal the pattern so far; only the new byte needs a compare.
  assign match    = (in_i.data_byte == lpcq_pkg::query_byte(cnt_q));
  assign complete = (cnt_q == lpcq_pkg::CntW'(lpcq_pkg::QueryLen - 1));

  always_comb begin
    cnt_d        = cnt_q;
    push_o       = 1'b0;
    cmd_o.reply  = match;
    cmd_o.nheld  = cnt_q;
    cmd_o.ch     = in_i.data_byte;
    if (accept) begin
      if (match && !complete) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        cnt_d  = '0;
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/lpcq_fifo.sv */
// Short command queue between front and back.
// Depends on lpcq_pkg.
`timescale 1ns / 1ps

module lpcq_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpcq_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output lpcq_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  lpcq_pkg::cmd_t             mem_q [lpcq_pkg::QDepth];
  logic [lpcq_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [lpcq_pkg::QCntW-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign full_o  = (cnt_q == lpcq_pkg::QCntW'(lpcq_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/lpcq_back.sv */
// Back end: replays held bytes, inserts the line prefix, drives the output register.
// Depends on lpcq_pkg and lpcq_out_if.
`timescale 1ns / 1ps

module lpcq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lpcq_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  input  lpcq_pkg::digits_t digits_i,
  lpcq_out_if.source        out_o
);

  logic [lpcq_pkg::CntW-1:0] idx_q, idx_d;
  logic [3:0]                step_q, step_d;
  logic                      at_ls_q, at_ls_d, prev_cr_q, prev_cr_d;
  logic                      ov_q, ov_d;
  logic [7:0]                ob_q, ob_d;
  logic                      orr_q, orr_d, ol_q, ol_d;

  logic [2:0] nd;
  logic [3:0] plen, dsel;
  logic [7:0] cur, pfx;
  logic       cur_last, need, in_pfx, fire;

  // Count significant decimal digits; zero still prints one digit.
  always_comb begin
    if (digits_i[4] != 4'd0)      nd = 3'd5;
    else if (digits_i[3] != 4'd0) nd = 3'd4;
    else if (digits_i[2] != 4'd0) nd = 3'd3;
    else if (digits_i[1] != 4'd0) nd = 3'd2;
    else                          nd = 3'd1;
  end

  assign plen = 4'd8 + {1'b0, nd};
  assign dsel = {1'b0, nd} + 4'd5 - step_q;

  always_comb begin
    if (step_q < 4'(lpcq_pkg::HeadLen)) begin
      pfx = lpcq_pkg::PfxHead[step_q[2:0]];
    end else if (step_q < 4'(lpcq_pkg::HeadLen) + {1'b0, nd}) begin
      pfx = lpcq_pkg::CharZero + {4'd0, digits_i[dsel[2:0]]};
    end else if (step_q == 4'(lpcq_pkg::HeadLen) + {1'b0, nd}) begin
      pfx = lpcq_pkg::CharClose;
    end else begin
      pfx = lpcq_pkg::CharSpace;
    end
  end

  assign cur_last = (idx_q == cmd_i.nheld);
  assign cur      = cur_last ? cmd_i.ch : lpcq_pkg::query_byte(idx_q);
  assign need     = at_ls_q && !(prev_cr_q && (cur == lpcq_pkg::CharLf));
  assign in_pfx   = need && (step_q < plen);
  assign fire     = cmd_valid_i && (!ov_q || out_o.ready);

  always_comb begin
    idx_d     = idx_q;
    step_d    = step_q;
    at_ls_d   = at_ls_q;
    prev_cr_d = prev_cr_q;
    ob_d      = ob_q;
    orr_d     = orr_q;
    ol_d      = ol_q;
    pop_o     = 1'b0;
    ov_d      = out_o.ready ? 1'b0 : ov_q;
    if (fire) begin
      ov_d = 1'b1;
      if (cmd_i.reply) begin
        ob_d  = 8'd0;
        orr_d = 1'b1;
        ol_d  = 1'b1;
        pop_o = 1'b1;
      end else if (in_pfx) begin
        ob_d   = pfx;
        orr_d  = 1'b0;
        ol_d   = 1'b0;
        step_d = step_q + 1'b1;
      end else begin
        ob_d      = cur;
        orr_d     = 1'b0;
        ol_d      = cur_last;
        step_d    = '0;
        at_ls_d   = (cur == lpcq_pkg::CharCr) || (cur == lpcq_pkg::CharLf);
        prev_cr_d = (cur == lpcq_pkg::CharCr);
        if (cur_last) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q  <= ob_d;
    orr_q <= orr_d;
    ol_q  <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      step_q    <= '0;
      at_ls_q   <= 1'b1;
      prev_cr_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      step_q    <= step_d;
      at_ls_q   <= at_ls_d;
      prev_cr_q <= prev_cr_d;
      ov_q      <= ov_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_byte      = ob_q;
  assign out_o.reply_request = orr_q;
  assign out_o.last          = ol_q;

endmodule

/* verif/tb_line_prefix_and_cursor_query_filter_top.sv */
// Self-checking testbench for line_prefix_and_cursor_query_filter_top.
// Drives console bytes, predicts prefixed bytes and cursor query replies, checks every transfer.
// Depends on lpcq_pkg, lpcq_in_if, lpcq_out_if and the filter RTL.
`timescale 1ns / 1ps

module tb_line_prefix_and_cursor_query_filter_top;

  // Console characters used by the stimulus and the predictor.
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChSix   = 8'h36;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Cursor position query; bytes past 'n' are zero for longer query lengths.
  localparam int unsigned QLen = lpcq_pkg::QueryLen;
  localparam logic [7:0] CursorQuery [8] = '{
    ChEsc, ChBrack, ChSix, ChN, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Settle time after the last expected result: covers a queued byte with
  // prefix and held bytes, plus the queue entries.
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       reply;
    logic       last;
  } filt_res_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [lpcq_pkg::VmW-1:0] cfg_wdata_i;

  lpcq_in_if  in_if ();
  lpcq_out_if out_if ();

  line_prefix_and_cursor_query_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predicted output stream, oldest first.
  filt_res_t filt_exp_q [$];

  // Shadow of the filter state.
  logic [15:0] vm_num;
  logic        at_bol;
  logic        prev_cr;
  int unsigned held_cnt;
  logic [7:0]  held_bytes [8];

  // Run statistics and pacing knobs.
  int items_sent;
  int results_seen;
  int replies_seen;
  int err_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  function automatic void push_result(input logic [7:0] b, input logic rq);
    filt_res_t r;
    r.ch    = b;
    r.reply = rq;
    r.last  = 1'b0;
    filt_exp_q.push_back(r);
  endfunction

  // Emit one visible byte, inserting the "[vmid N] " prefix at a line start.
  // A LF directly after a CR continues the CR's line and gets no prefix.
  function automatic void emit_visible_byte(input logic [7:0] ch);
    string pfx;
    int    i;
    if (at_bol && (!prev_cr || ch != ChLf)) begin
      pfx = $sformatf("[vmid %0d] ", vm_num);
      for (i = 0; i < pfx.len(); i++) push_result(pfx[i], 1'b0);
      at_bol = 1'b0;
    end
    push_result(ch, 1'b0);
    if (ch == ChCr) begin
      at_bol  = 1'b1;
      prev_cr = 1'b1;
    end else if (ch == ChLf) begin
      at_bol  = 1'b1;
      prev_cr = 1'b0;
    end else begin
      prev_cr = 1'b0;
    end
  endfunction

  // Work out every result that one accepted console byte causes.
  function automatic void predict_console_byte(input logic [7:0] ch);
    int   n0;
    int   i;
    logic hit;
    n0  = filt_exp_q.size();
    hit = 1'b1;
    if (held_cnt != 0 || ch == CursorQuery[0]) begin
      if (held_cnt < QLen) begin
        held_bytes[held_cnt] = ch;
        held_cnt++;
      end
      for (i = 0; i < held_cnt; i++)
        if (held_bytes[i] != CursorQuery[i]) hit = 1'b0;
      if (hit) begin
        // Partial match stays held; a complete one becomes a reply request.
        if (held_cnt >= QLen) begin
          held_cnt = 0;
          push_result(8'h00, 1'b1);
        end
      end else begin
        // Mismatch: replay everything held, the breaking byte included.
        for (i = 0; i < held_cnt; i++) emit_visible_byte(held_bytes[i]);
        held_cnt = 0;
      end
    end else begin
      emit_visible_byte(ch);
    end
    if (filt_exp_q.size() > n0) filt_exp_q[filt_exp_q.size() - 1].last = 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Clock, reset watchdog
  // -------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A generous time bound for the whole run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected", filt_exp_q.size());
    $display("** line_prefix_and_cursor_query_filter_top: FAILED **");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // -------------------------------------------------------------------------

  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Checker: compare each output transfer with the oldest prediction
  // -------------------------------------------------------------------------

  always @(posedge clk_i) begin
    filt_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (filt_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected result byte=%02h reply=%0b last=%0b", $realtime,
                   out_if.out_byte, out_if.reply_request, out_if.last);
      end else begin
        want = filt_exp_q.pop_front();
        if (want.reply) replies_seen++;
        if (out_if.out_byte !== want.ch || out_if.reply_request !== want.reply ||
            out_if.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: byte/reply/last exp %02h/%0b/%0b got %02h/%0b/%0b",
                     $realtime, want.ch, want.reply, want.last,
                     out_if.out_byte, out_if.reply_request, out_if.last);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Shared stimulus tasks
  // -------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it, and hold it until
  // the transfer. Valid stays high afterwards so back-to-back bytes flow.
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_console_byte(b);
    items_sent++;
  endtask

  // Drop valid and wait until every prediction has arrived, then let the
  // block settle in case the last bytes only filled the hold register.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (filt_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_vm_number(input logic [15:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vm_num = v;
  endtask

  task automatic send_query_prefix(input int n);
    int i;
    for (i = 0; i < n; i++) send_byte(CursorQuery[i]);
  endtask

  // One random sequence, mostly well formed: full queries, broken queries,
  // line endings and text; the rest is raw noise.
  task automatic send_random_seq();
    int kind;
    int n;
    int i;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_query_prefix(QLen);
    end else if (kind < 45) begin
      send_query_prefix($urandom_range(QLen - 1, 1));
      if ($urandom_range(1)) send_byte(ChEsc);
      else send_byte(8'($urandom_range(255)));
    end else if (kind < 65) begin
      case ($urandom_range(3))
        0: send_byte(ChCr);
        1: send_byte(ChLf);
        2: begin
          send_byte(ChCr);
          send_byte(ChLf);
        end
        default: begin
          send_byte(ChLf);
          send_byte(ChCr);
        end
      endcase
    end else if (kind < 90) begin
      n = $urandom_range(4, 1);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(8'h7E, 8'h20)));
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_items(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_seq();
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Extremes of the byte, line endings, and each query case, with the
  // reset machine number and no idling on either side.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(8'h41);          // first byte of the run gets a prefix
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ChCr);
    send_byte(ChLf);           // LF right after CR: no new prefix
    send_byte(ChLf);           // bare LF at a line start: prefixed
    send_byte(ChLf);
    send_query_prefix(QLen);   // complete query at a line start
    send_query_prefix(2);
    send_byte(8'h58);          // broken query replayed with a prefix
    send_byte(ChEsc);
    send_byte(ChEsc);          // second ESC breaks, does not restart
    send_query_prefix(3);
    send_byte(ChCr);           // break on CR right before 'n'
    send_byte(ChCr);
    send_byte(8'h7A);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering, so the queue fills and input ready drops.
  task automatic test_backpressure_fill();
    write_vm_number(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 400;
    run_random_items(40);
    wait_drained();
  endtask

  // Pause the sender mid-stream until the output has fully drained.
  task automatic test_sender_pause();
    write_vm_number(16'd7);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    run_random_items(15);
    wait_drained();
    run_random_items(15);
    wait_drained();
  endtask

  task automatic test_random_phase(input logic [15:0] vm, input int idle_pct,
                                   input int stall_pct);
    write_vm_number(vm);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random_items(85);
    wait_drained();
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------

  initial begin
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    vm_num          = 16'd0;
    at_bol          = 1'b1;
    prev_cr         = 1'b0;
    held_cnt        = 0;
    items_sent      = 0;
    results_seen    = 0;
    replies_seen    = 0;
    err_cnt         = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure_fill();
    test_sender_pause();
    test_random_phase(16'd0, 0, 0);
    test_random_phase(16'd10, 81, 0);
    test_random_phase(16'($urandom_range(65534, 1)), 0, 81);
    test_random_phase(16'hFFFF, 36, 36);
    wait_drained();

    if (filt_exp_q.size() != 0) err_cnt++;
    $display("Sent %0d console bytes; checked %0d output transfers, %0d of them query replies,",
             items_sent, results_seen, replies_seen);
    $display("over seven phases of prefix numbers and idle patterns, %0d mismatches.", err_cnt);
    if (err_cnt == 0) begin
      $display("** line_prefix_and_cursor_query_filter_top: PASSED **");
    end else begin
      $display("** line_prefix_and_cursor_query_filter_top: FAILED **");
    end
    $finish;
  end

endmodule
